/* src/nmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared widths, divide-by-nine constants and the result tag for the
// 3x3 neighbor mean filter.
// ----------------------------------------------------------------------------
package nmf_pkg;

  // pixel and result value width
  localparam int PIXEL_BITS = 16;
  // position fields on the output
  localparam int POS_BITS   = 6;
  // side length register
  localparam int CFG_W      = 7;
  localparam logic [CFG_W-1:0] SIDE_RESET = 7'd8;

  // sum of eight signed pixels
  localparam int SUM_W = PIXEL_BITS + 3;

  // floor(x / 9) == (x * RECIP) >> RECIP_SHIFT for 0 <= x <= 2**(SUM_W-1)
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP = 19'd466034;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // stream widths, whole bytes
  localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = PIXEL_BITS + 2 * POS_BITS;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
  } tag_t;

endpackage

/* src/nmf_div9.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmf_div9
// Two-stage signed divide by nine, truncating toward zero. Stage one takes
// the magnitude and multiplies by the reciprocal; stage two shifts and
// restores the sign. The second stage is the block's output register.
// ----------------------------------------------------------------------------
module nmf_div9 import nmf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SUM_W-1:0]      in_sum,
  input  tag_t                         in_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PIXEL_BITS-1:0] out_quot,
  output tag_t                         out_tag
);

  logic              p_valid;
  logic [PROD_W-1:0] p_prod;
  logic              p_neg;
  tag_t              p_tag;
  logic              p_ready;

  logic [SUM_W-1:0]      mag;
  logic [PROD_W-1:0]     prod;
  logic [PIXEL_BITS-1:0] quot;

  assign mag  = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
  assign prod = mag * RECIP;

  assign p_ready  = !out_valid || out_ready;
  assign in_ready = !p_valid || p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_ready) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_prod <= prod;
      p_neg  <= in_sum[SUM_W-1];
      p_tag  <= in_tag;
    end
  end

  assign quot = p_prod[RECIP_SHIFT +: PIXEL_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_ready) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && p_valid) begin
      out_quot <= p_neg ? -quot : quot;
      out_tag  <= p_tag;
    end
  end

endmodule

/* src/neighbor_mean_filter_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_mean_filter_3x3
// Streaming 3x3 neighbor mean with zero padding over a square image. The
// eight pixels around each position are summed (center excluded) and divided
// by nine toward zero. Two earlier rows live in a three-row line store.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | content
//  ---------+-----------+----------------------------+---------------------------
//  s_axis   | in        | s_axis_tvalid/tready       | tdata[15:0] pixel
//  m_axis   | out       | m_axis_tvalid/tready       | tdata filtered,row,col; tlast
//  cfg      | in        | cfg_valid/cfg_ready        | cfg_data side_length
//
//  - One pixel transaction per cycle while s_axis_tready is high; a pixel gives
//    one result per cycle in steady state. Pixels that give two or four
//    results (last column, last row) hold s_axis_tready low while the single
//    result issue slot in front of the sum stage works through them.
//  - A pixel transaction reaches its first result on m_axis through the store
//    read, window, sum, multiply and output registers.
//  - The line store has one write and two read ports; its contents are not
//    cleared, the row position masks rows above the image.
//  - rst is synchronous; it clears valids and counters and sets side_length to 8.
//  - A cfg transaction restarts the image at row 0, column 0.
//  - A stalled m_axis backs up through the pipeline to s_axis_tready.
// ----------------------------------------------------------------------------
module neighbor_mean_filter_3x3 import nmf_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // pixel input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] pixel
  // filtered output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] filtered, [21:16] out_row,
                                                 // [27:22] out_col, rest zero
  output logic                   m_axis_tlast,   // last result of the image
  // side length register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int DEPTH  = 3 * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);

  // result codes within one pixel, in emission order
  localparam logic [1:0] RES_UP_LEFT = 2'd0;   // (r-1, c-1)
  localparam logic [1:0] RES_UP      = 2'd1;   // (r-1, c) on last column
  localparam logic [1:0] RES_LEFT    = 2'd2;   // (r, c-1) on last row
  localparam logic [1:0] RES_HERE    = 2'd3;   // (r, c) on final pixel

  // --------------------------------------------------------------------------
  // configuration and position counters
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] side_length;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] row_cnt;
  logic [CNT_W-1:0] col_cnt;
  logic [1:0]       slot;       // row_cnt mod 3
  logic             in_acc;
  logic             cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // effective side: 0 acts as 1, above MAX_SIDE clamps
  always_comb begin
    if (side_length == '0) begin
      last_idx = '0;
    end else if (32'(side_length) > MAX_SIDE) begin
      last_idx = CNT_W'(MAX_SIDE - 1);
    end else begin
      last_idx = CNT_W'(side_length - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= SIDE_RESET;
      row_cnt     <= '0;
      col_cnt     <= '0;
      slot        <= '0;
    end else if (cfg_acc) begin
      side_length <= cfg_data;
      row_cnt     <= '0;
      col_cnt     <= '0;
      slot        <= '0;
    end else if (in_acc) begin
      if (col_cnt == last_idx) begin
        col_cnt <= '0;
        if (row_cnt == last_idx) begin
          row_cnt <= '0;
          slot    <= '0;
        end else begin
          row_cnt <= row_cnt + 1'b1;
          slot    <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
        end
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // line store: write row r, read column c of rows r-1 and r-2
  // --------------------------------------------------------------------------
  logic signed [PIXEL_BITS-1:0] store [DEPTH];
  logic signed [PIXEL_BITS-1:0] rd_up1;
  logic signed [PIXEL_BITS-1:0] rd_up2;
  logic [1:0]        slot_up1;
  logic [1:0]        slot_up2;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] addr_up1;
  logic [ADDR_W-1:0] addr_up2;

  function automatic logic [ADDR_W-1:0] row_base(input logic [1:0] s);
    logic [ADDR_W-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = ADDR_W'(MAX_SIDE);
      default: b = ADDR_W'(2 * MAX_SIDE);
    endcase
    return b;
  endfunction

  assign slot_up1 = (slot == 2'd0) ? 2'd2 : slot - 2'd1;
  assign slot_up2 = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
  assign wr_addr  = row_base(slot)     + ADDR_W'(col_cnt);
  assign addr_up1 = row_base(slot_up1) + ADDR_W'(col_cnt);
  assign addr_up2 = row_base(slot_up2) + ADDR_W'(col_cnt);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[wr_addr] <= s_axis_tdata[PIXEL_BITS-1:0];
      rd_up1         <= store[addr_up1];
      rd_up2         <= store[addr_up2];
    end
  end

  // --------------------------------------------------------------------------
  // stage A: pixel waits for store read data
  // --------------------------------------------------------------------------
  logic                         a_valid;
  logic signed [PIXEL_BITS-1:0] a_pixel;
  logic [CNT_W-1:0]             a_row;
  logic [CNT_W-1:0]             a_col;
  logic                         a_has_up1;
  logic                         a_has_up2;
  logic [3:0]                   a_mask;
  logic                         a_adv;
  logic                         e_free;
  logic                         row_last;
  logic                         col_last;

  assign row_last      = (row_cnt == last_idx);
  assign col_last      = (col_cnt == last_idx);
  assign a_adv         = a_valid && e_free;
  assign s_axis_tready = !a_valid || e_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pixel   <= s_axis_tdata[PIXEL_BITS-1:0];
      a_row     <= row_cnt;
      a_col     <= col_cnt;
      a_has_up1 <= (row_cnt != '0);
      a_has_up2 <= (row_cnt > CNT_W'(1));
      a_mask[RES_UP_LEFT] <= (row_cnt != '0) && (col_cnt != '0);
      a_mask[RES_UP]      <= (row_cnt != '0) && col_last;
      a_mask[RES_LEFT]    <= row_last && (col_cnt != '0);
      a_mask[RES_HERE]    <= row_last && col_last;
    end
  end

  // --------------------------------------------------------------------------
  // stage E: 3x3 window (rows r-2..r, cols c-2..c) and result issue
  // --------------------------------------------------------------------------
  logic signed [PIXEL_BITS-1:0] win [3][3];
  logic [3:0]       e_mask;
  logic [3:0]       e_mask_next;
  logic [CNT_W-1:0] e_row;
  logic [CNT_W-1:0] e_col;
  logic [1:0]       sel;
  logic             e_issue;
  logic             s_ready;

  always_comb begin
    if (e_mask[RES_UP_LEFT]) begin
      sel = RES_UP_LEFT;
    end else if (e_mask[RES_UP]) begin
      sel = RES_UP;
    end else if (e_mask[RES_LEFT]) begin
      sel = RES_LEFT;
    end else begin
      sel = RES_HERE;
    end
  end

  assign e_issue     = (e_mask != '0) && s_ready;
  assign e_mask_next = e_issue ? (e_mask & ~(4'b0001 << sel)) : e_mask;
  assign e_free      = (e_mask_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_mask <= '0;
    end else if (a_adv) begin
      e_mask <= a_mask;
    end else begin
      e_mask <= e_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      e_row     <= a_row;
      e_col     <= a_col;
      win[0][2] <= a_has_up2 ? rd_up2 : '0;
      win[1][2] <= a_has_up1 ? rd_up1 : '0;
      win[2][2] <= a_pixel;
      for (int i = 0; i < 3; i++) begin
        // column 0 starts with padding on the left
        win[i][1] <= (a_col == '0) ? '0 : win[i][2];
        win[i][0] <= (a_col == '0) ? '0 : win[i][1];
      end
    end
  end

  // neighbor sum around the selected center; row 3 and column 3 are padding
  logic signed [SUM_W-1:0]      e_sum;
  logic signed [PIXEL_BITS-1:0] grid [4][4];
  tag_t                         e_tag;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        grid[i][j] = (i < 3 && j < 3) ? win[i % 3][j % 3] : '0;
      end
    end
  end

  always_comb begin
    e_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i != 1 || j != 1) begin
          e_sum = e_sum + SUM_W'(grid[2'(i) + {1'b0, sel[1]}][2'(j) + {1'b0, sel[0]}]);
        end
      end
    end
  end

  assign e_tag.row  = POS_BITS'(sel[1] ? e_row : e_row - 1'b1);
  assign e_tag.col  = POS_BITS'(sel[0] ? e_col : e_col - 1'b1);
  assign e_tag.last = (sel == RES_HERE);

  // --------------------------------------------------------------------------
  // stage S: registered sum, then divide and output register
  // --------------------------------------------------------------------------
  logic                    s_valid;
  logic signed [SUM_W-1:0] s_sum;
  tag_t                    s_tag;
  logic                    div_ready;
  logic signed [PIXEL_BITS-1:0] out_quot;
  tag_t                    out_tag;

  assign s_ready = !s_valid || div_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_ready) begin
      s_valid <= e_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (e_issue) begin
      s_sum <= e_sum;
      s_tag <= e_tag;
    end
  end

  nmf_div9 u_div9 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (div_ready),
    .in_sum    (s_sum),
    .in_tag    (s_tag),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_quot  (out_quot),
    .out_tag   (out_tag)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_tag.col, out_tag.row, out_quot};
  assign m_axis_tlast = out_tag.last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (row_cnt <= last_idx) && (col_cnt <= last_idx))
    else $error("position counter beyond image side");

  a_wrap_at_end: assert property (@(posedge clk) disable iff (rst)
    in_acc && row_last && col_last |=> (row_cnt == '0) && (col_cnt == '0) && (slot == 2'd0))
    else $error("counters did not wrap after the final pixel");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    s_valid && !div_ready |=> s_valid && $stable(s_sum) && $stable(s_tag))
    else $error("sum stage changed while stalled");

  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> (out_tag.row == out_tag.col))
    else $error("last result not on the corner position");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    a_adv |-> !e_issue || $onehot(e_mask))
    else $error("window replaced while results still pending");

endmodule

/* sim/neighbor_mean_filter_3x3_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_mean_filter_3x3_test
// Self-checking bench for the 3x3 neighbor mean filter. A directed table
// covers the single-pixel images, the smallest images and the output value
// extremes. Random images of many side lengths follow, with some partial
// images cut short by a restart. Every result transaction is checked in order
// against a line-store model kept inside the bench, with random gaps on both
// streams.
// ----------------------------------------------------------------------------
module neighbor_mean_filter_3x3_test import nmf_pkg::*;;

  localparam int IMG_MAX      = 64;   // dut MAX_SIDE default
  localparam int NEIGHBOR_DIV = 9;    // eight neighbors, divided by nine
  localparam int PIPE_SETTLE  = 8;    // cycles past the pipeline latency
  localparam int RANDOM_ITEMS = 310;  // pixel transactions over the whole run

  // one result transaction as the bench sees it
  typedef struct packed {
    logic [PIXEL_BITS-1:0] value;
    tag_t                  tag;
  } filt_result_t;

  // directed table rows
  typedef enum logic [1:0] {ROW_SIDE, ROW_PIXEL, ROW_PIXEL_TYPED} dir_kind_t;

  typedef struct packed {
    dir_kind_t             kind;
    logic [PIXEL_BITS-1:0] data;        // side length or pixel
    logic [PIXEL_BITS-1:0] want_value;  // typed rows only
    logic                  want_last;   // typed rows only
  } dir_row_t;

  localparam logic [PIXEL_BITS-1:0] PIX_MAX = 16'h7FFF;
  localparam logic [PIXEL_BITS-1:0] PIX_MIN = 16'h8000;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // single pixel image: no neighbors, mean 0, last set
    '{ROW_SIDE,        16'd1,   16'd0, 1'b0},
    '{ROW_PIXEL_TYPED, PIX_MAX, 16'd0, 1'b1},
    // side 0 behaves as side 1
    '{ROW_SIDE,        16'd0,   16'd0, 1'b0},
    '{ROW_PIXEL_TYPED, PIX_MIN, 16'd0, 1'b1},
    // 2x2: all four results fall on the final pixel
    '{ROW_SIDE,        16'd2,   16'd0, 1'b0},
    '{ROW_PIXEL,       16'h0001, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       16'hFFFF, 16'd0, 1'b0},
    // 3x3 all max: center hits the top output value
    '{ROW_SIDE,        16'd3,   16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MAX, 16'd0, 1'b0},
    // second image with no restart, all min: bottom output value
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0},
    '{ROW_PIXEL,       PIX_MIN, 16'd0, 1'b0}
  };

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] pixel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [15:0] filtered, [21:16] out_row,
                                          // [27:22] out_col, rest zero
  logic                   m_axis_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  neighbor_mean_filter_3x3 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Filter model: three-row ring of pixels plus the next write position.
  // --------------------------------------------------------------------------
  logic signed [PIXEL_BITS-1:0] line_rows [3][IMG_MAX];
  int img_side = 8;     // side after reset
  int next_row = 0;
  int next_col = 0;

  filt_result_t mean_queue [$];   // results still owed by the dut

  int mismatch_count = 0;
  int results_checked = 0;
  int pixels_sent = 0;
  int images_done = 0;
  int side_writes = 0;

  // eight-neighbor sum, zero outside the image
  function automatic int window_sum(input int i, input int j);
    int s = 0;
    for (int di = -1; di <= 1; di++)
      for (int dj = -1; dj <= 1; dj++)
        if ((di != 0 || dj != 0) && i + di >= 0 && i + di < img_side &&
            j + dj >= 0 && j + dj < img_side)
          s += line_rows[(i + di) % 3][j + dj];
    return s;
  endfunction

  // store one pixel; every position whose last neighbor this is comes out
  function automatic void filter_pixel(input logic [PIXEL_BITS-1:0] px,
                                       output filt_result_t res [4], output int n);
    int r, c, nr, nc, m;
    int rows [2];
    int cols [2];
    r = next_row;
    c = next_col;
    n = 0;
    nr = 0;
    nc = 0;
    line_rows[r % 3][c] = px;
    if (r > 0) begin
      rows[nr] = r - 1;
      nr++;
    end
    if (r == img_side - 1) begin
      rows[nr] = r;
      nr++;
    end
    if (c > 0) begin
      cols[nc] = c - 1;
      nc++;
    end
    if (c == img_side - 1) begin
      cols[nc] = c;
      nc++;
    end
    for (int a = 0; a < nr; a++) begin
      for (int b = 0; b < nc; b++) begin
        m = window_sum(rows[a], cols[b]) / NEIGHBOR_DIV;  // truncates toward zero
        res[n].value    = m[PIXEL_BITS-1:0];
        res[n].tag.row  = rows[a][POS_BITS-1:0];
        res[n].tag.col  = cols[b][POS_BITS-1:0];
        res[n].tag.last = (rows[a] == img_side - 1) && (cols[b] == img_side - 1);
        n++;
      end
    end
    // advance, wrapping at the end of the image
    c++;
    if (c >= img_side) begin
      c = 0;
      r++;
      if (r >= img_side) begin
        r = 0;
        images_done++;
      end
    end
    next_row = r;
    next_col = c;
  endfunction

  // predicted results of an accepted pixel go onto the queue
  function automatic void track_pixel(input logic [PIXEL_BITS-1:0] px);
    filt_result_t res [4];
    int n;
    filter_pixel(px, res, n);
    for (int k = 0; k < n; k++) mean_queue.push_back(res[k]);
    pixels_sent++;
  endfunction

  // --------------------------------------------------------------------------
  // Random choices
  // --------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    logic [31:0] w;
    w = $urandom;
    case (w[31:29])
      3'd0: return PIX_MAX;
      3'd1: return PIX_MIN;
      3'd2: return {{(PIXEL_BITS-4){w[3]}}, w[3:0]};  // small, either sign
      default: return w[PIXEL_BITS-1:0];
    endcase
  endfunction

  function automatic int side_in_use(input logic [CFG_W-1:0] side);
    if (side == '0) return 1;
    if (side > IMG_MAX) return IMG_MAX;
    return side;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  // one pixel transaction; tvalid stays high when the next one follows at once
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] px, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= px;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop sending and let every owed result come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk);
    // pixels with no result may still be in flight
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // side_length write, only with the dut idle; it restarts the image
  task automatic write_side(input logic [CFG_W-1:0] side);
    drain_results();
    cfg_data  <= side;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    img_side = side_in_use(side);
    next_row = 0;
    next_col = 0;
    side_writes++;
  endtask

  // new side, then count pixels; pause_at >= 0 drains once mid-stream
  task automatic run_phase(input logic [CFG_W-1:0] side, input int count,
                           input bit steady, input int pause_at);
    logic [PIXEL_BITS-1:0] px;
    write_side(side);
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) drain_results();
      px = rand_pixel();
      send_pixel(px, steady ? 0 : pick_gap());
      track_pixel(px);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready with random stalls, some long stretches always ready
  // --------------------------------------------------------------------------
  int  rx_hold = 0;
  int  rx_stall = 0;
  int  rx_roll;
  bit  rx_steady = 1'b0;

  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_steady <= ($urandom_range(0, 3) == 0);
      rx_hold   <= $urandom_range(30, 150);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall      <= rx_stall - 1;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 19);
      if (rx_roll < 13) begin
        m_axis_tready <= 1'b1;
      end else if (rx_roll < 19) begin
        m_axis_tready <= 1'b0;
        rx_stall      <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        rx_stall      <= $urandom_range(8, 25);
      end
    end
  end

  task automatic report_bad(input string what, input filt_result_t want,
                            input filt_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("ERROR %s: want %0d (%0d,%0d) last %0b, got %0d (%0d,%0d) last %0b",
               what, $signed(want.value), want.tag.row, want.tag.col, want.tag.last,
               $signed(got.value), got.tag.row, got.tag.col, got.tag.last);
  endtask

  // every result transaction against the oldest owed result
  filt_result_t got_res;
  filt_result_t want_res;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res.value    = m_axis_tdata[0 +: PIXEL_BITS];
      got_res.tag.row  = m_axis_tdata[PIXEL_BITS +: POS_BITS];
      got_res.tag.col  = m_axis_tdata[PIXEL_BITS + POS_BITS +: POS_BITS];
      got_res.tag.last = m_axis_tlast;
      results_checked++;
      if (mean_queue.size() == 0) begin
        report_bad("unexpected result", got_res, got_res);
      end else begin
        want_res = mean_queue.pop_front();
        if (got_res.value !== want_res.value)
          report_bad("filtered", want_res, got_res);
        else if (got_res.tag.row !== want_res.tag.row)
          report_bad("out_row", want_res, got_res);
        else if (got_res.tag.col !== want_res.tag.col)
          report_bad("out_col", want_res, got_res);
        else if (got_res.tag.last !== want_res.tag.last)
          report_bad("last", want_res, got_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pick, eff, count;
    filt_result_t typed_res;
    filt_result_t res [4];
    int n;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int k = 0; k < DIR_ROWS; k++) begin
      case (DIR_TABLE[k].kind)
        ROW_SIDE: begin
          write_side(DIR_TABLE[k].data[CFG_W-1:0]);
        end
        ROW_PIXEL_TYPED: begin
          send_pixel(DIR_TABLE[k].data, pick_gap());
          filter_pixel(DIR_TABLE[k].data, res, n);  // keeps the store in step
          typed_res.value    = DIR_TABLE[k].want_value;
          typed_res.tag.row  = '0;
          typed_res.tag.col  = '0;
          typed_res.tag.last = DIR_TABLE[k].want_last;
          mean_queue.push_back(typed_res);
          pixels_sent++;
        end
        default: begin
          send_pixel(DIR_TABLE[k].data, pick_gap());
          track_pixel(DIR_TABLE[k].data);
        end
      endcase
    end

    // largest side, first rows only, with a full drain partway through
    run_phase(7'd64, IMG_MAX + 8, 1'b0, IMG_MAX / 2);
    // register above range acts as the largest side; back to back
    run_phase(7'd127, IMG_MAX + 2, 1'b1, -1);
    // one mid-size partial image
    pick = $urandom_range(11, 40);
    run_phase(pick[CFG_W-1:0], pick + 5, 1'b0, -1);

    // mostly whole small images, some cut short by a restart
    while (pixels_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 7);
      eff = side_in_use(pick[CFG_W-1:0]);
      if ($urandom_range(0, 4) == 0)
        count = $urandom_range(1, eff * eff);
      else
        count = eff * eff * $urandom_range(1, 3);
      // stop at the planned pixel total
      if (count > RANDOM_ITEMS - pixels_sent)
        count = RANDOM_ITEMS - pixels_sent;
      run_phase(pick[CFG_W-1:0], count, ($urandom_range(0, 3) == 0),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1);
    end

    drain_results();
    repeat (PIPE_SETTLE) @(posedge clk);
    if (mean_queue.size() != 0) begin
      mismatch_count++;
      $display("ERROR %0d results never arrived", mean_queue.size());
    end

    $display("Covered %0d pixels, %0d whole images, %0d side writes (0, 1..7, 64, 127)",
             pixels_sent, images_done, side_writes);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
